// ===== design/prc_pkg.sv =====
// Package for the press rate meter: sizes, register indexes and reset values,
// and the control bundle that steers the timestamp chain.
// No dependencies.
package prc_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);

  localparam int TIME_W   = 32;
  localparam int READ_W   = 16;
  localparam int WEIGHT_W = 8;
  localparam int RATE_W   = 14;
  localparam int PROD_W   = CNT_W + WEIGHT_W;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW          = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_PER_PRESS  = 4'd3;

  localparam logic [READ_W-1:0]   RST_PRESS_THRESHOLD = 16'd100;
  localparam logic [TIME_W-1:0]   RST_REFRESH_PERIOD  = 32'd1000;
  localparam logic [TIME_W-1:0]   RST_WINDOW          = 32'd10000;
  localparam logic [WEIGHT_W-1:0] RST_RATE_PER_PRESS  = 8'd6;

  // Chain control: insert pushes a new stamp at the head, rotate recirculates
  // the tail into the head. The two never occur in the same cycle.
  typedef struct packed {
    logic              insert;
    logic              rotate;
    logic [TIME_W-1:0] new_time;
  } prc_chain_ctrl_t;

endpackage

// ===== design/prc_cell.sv =====
// One storage cell of the timestamp chain: a stamp and its valid bit.
// Depends on prc_pkg.
module prc_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic [prc_pkg::TIME_W-1:0] time_in,
  input  logic                      valid_in,
  output logic [prc_pkg::TIME_W-1:0] time_out,
  output logic                      valid_out
);

  always_ff @(posedge clk) begin
    if (shift) begin
      time_out <= time_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (shift) begin
      valid_out <= valid_in;
    end
  end

endmodule

// ===== design/prc_chain.sv =====
// Row of DEPTH timestamp cells. Insert drops the oldest stamp off the tail;
// rotate recirculates the tail into the head; DEPTH rotates walk every stamp past the tail.
// Depends on prc_pkg and prc_cell.
module prc_chain (
  input  logic                       clk,
  input  logic                       rst,
  input  prc_pkg::prc_chain_ctrl_t   ctrl,
  output logic [prc_pkg::TIME_W-1:0] tail_time,
  output logic                       tail_valid
);

  logic [prc_pkg::TIME_W-1:0] cell_time  [prc_pkg::DEPTH];
  logic                       cell_valid [prc_pkg::DEPTH];
  logic [prc_pkg::TIME_W-1:0] head_time;
  logic                       head_valid;
  logic                       shift;

  assign shift      = ctrl.insert | ctrl.rotate;
  assign tail_time  = cell_time[prc_pkg::DEPTH-1];
  assign tail_valid = cell_valid[prc_pkg::DEPTH-1];

  // Head takes the new press, or the tail when recirculating.
  always_comb begin
    if (ctrl.insert) begin
      head_time  = ctrl.new_time;
      head_valid = 1'b1;
    end else begin
      head_time  = tail_time;
      head_valid = tail_valid;
    end
  end

  for (genvar i = 0; i < prc_pkg::DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      prc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .time_in   (head_time),
        .valid_in  (head_valid),
        .time_out  (cell_time[i]),
        .valid_out (cell_valid[i])
      );
    end else begin : g_body
      prc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (shift),
        .time_in   (cell_time[i-1]),
        .valid_in  (cell_valid[i-1]),
        .time_out  (cell_time[i]),
        .valid_out (cell_valid[i])
      );
    end
  end

endmodule

// ===== design/press_rate_meter.sv =====
// Top level of the press rate meter: input and output channels, configuration
// registers, press detection, age scan over the timestamp chain and rate.
// Depends on prc_pkg and prc_chain.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one sample: reading and now_ms.
//   Output channel (out_valid / out_stall) returns one result per sample:
//   rate, rate_updated and pressing. A transfer happens on a rising edge with
//   valid high and stall low.
//   Press detection and the ring write happen in the cycle the sample is
//   taken. When the refresh period has elapsed, the stored stamps rotate once
//   around the cell chain, one stamp per cycle past a single age comparator,
//   so a recomputing sample passes through the scan state before its result
//   is made; any other sample goes straight to the final state. One sample
//   is in work at a time; the next is taken as soon as the block returns to
//   idle, even while the previous result still sits in the output register.
//   If the receiver stalls, the result holds in the output register and the
//   block waits in its final state with the next result until the register
//   frees up.
//   rst (synchronous, active high) clears all stamps' valid bits, the press
//   state, the last update time and the rate, and loads register defaults.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//   indexes beyond the register list are dropped.
module press_rate_meter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [prc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [prc_pkg::READ_W-1:0]        reading,
  input  logic [prc_pkg::TIME_W-1:0]        now_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [prc_pkg::RATE_W-1:0]        rate,
  output logic                              rate_updated,
  output logic                              pressing
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Configuration registers
  logic [prc_pkg::READ_W-1:0]   press_threshold;
  logic [prc_pkg::TIME_W-1:0]   refresh_period_ms;
  logic [prc_pkg::TIME_W-1:0]   window_ms;
  logic [prc_pkg::WEIGHT_W-1:0] rate_per_press;

  // Block state
  logic [1:0]                   state;
  logic                         press_active;
  logic [prc_pkg::TIME_W-1:0]   last_update_ms;
  logic [prc_pkg::RATE_W-1:0]   rate_value;
  logic [prc_pkg::TIME_W-1:0]   now_q;
  logic                         refresh_q;
  logic [prc_pkg::IDX_W-1:0]    scan_idx;
  logic [prc_pkg::CNT_W-1:0]    count;

  logic                         in_accept;
  logic                         press_new;
  logic                         refresh_hit;
  logic [prc_pkg::TIME_W-1:0]   elapsed;
  logic [prc_pkg::TIME_W-1:0]   tail_time;
  logic                         tail_valid;
  logic [prc_pkg::TIME_W-1:0]   tail_age;
  logic                         tail_young;
  logic                         out_free;
  logic [prc_pkg::PROD_W-1:0]   product;
  logic [prc_pkg::PROD_W+prc_pkg::RATE_W-1:0] product_ext;
  logic [prc_pkg::RATE_W-1:0]   rate_next;
  prc_pkg::prc_chain_ctrl_t     chain_ctrl;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      press_threshold   <= prc_pkg::RST_PRESS_THRESHOLD;
      refresh_period_ms <= prc_pkg::RST_REFRESH_PERIOD;
      window_ms         <= prc_pkg::RST_WINDOW;
      rate_per_press    <= prc_pkg::RST_RATE_PER_PRESS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prc_pkg::REG_PRESS_THRESHOLD: press_threshold   <= cfg_data[prc_pkg::READ_W-1:0];
        prc_pkg::REG_REFRESH_PERIOD:  refresh_period_ms <= cfg_data[prc_pkg::TIME_W-1:0];
        prc_pkg::REG_WINDOW:          window_ms         <= cfg_data[prc_pkg::TIME_W-1:0];
        prc_pkg::REG_RATE_PER_PRESS:  rate_per_press    <= cfg_data[prc_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a sample only when idle
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid & ~in_stall;

  // Press detection and refresh decision happen on the accepted sample
  assign press_new   = (reading > press_threshold) & ~press_active;
  assign elapsed     = now_ms - last_update_ms;
  assign refresh_hit = elapsed > refresh_period_ms;

  // Push a new press at the chain head; rotate the chain while scanning
  always_comb begin
    chain_ctrl.insert   = in_accept & press_new;
    chain_ctrl.rotate   = (state == ST_SCAN);
    chain_ctrl.new_time = now_ms;
  end

  prc_chain u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (chain_ctrl),
    .tail_time  (tail_time),
    .tail_valid (tail_valid)
  );

  // One age compare per cycle at the chain tail
  assign tail_age   = now_q - tail_time;
  assign tail_young = tail_valid & (tail_age < window_ms);

  // Rate from count; keep the low RATE_W bits
  assign product     = prc_pkg::PROD_W'(count) * prc_pkg::PROD_W'(rate_per_press);
  assign product_ext = {{prc_pkg::RATE_W{1'b0}}, product};
  assign rate_next   = refresh_q ? product_ext[prc_pkg::RATE_W-1:0] : rate_value;

  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      now_q     <= now_ms;
      refresh_q <= refresh_hit;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      press_active   <= 1'b0;
      last_update_ms <= '0;
      rate_value     <= '0;
      scan_idx       <= '0;
      count          <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (press_new) begin
              press_active <= 1'b1;
            end else if (reading == '0) begin
              press_active <= 1'b0;
            end
            scan_idx <= '0;
            count    <= '0;
            if (refresh_hit) begin
              last_update_ms <= now_ms;
              state          <= ST_SCAN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SCAN: begin
          if (tail_young) begin
            count <= count + prc_pkg::CNT_W'(1);
          end
          scan_idx <= scan_idx + prc_pkg::IDX_W'(1);
          if (scan_idx == prc_pkg::IDX_W'(prc_pkg::DEPTH - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Hold until the output register frees up
          if (out_free) begin
            rate_value <= rate_next;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      rate         <= rate_next;
      rate_updated <= refresh_q;
      pressing     <= press_active;
    end
  end

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state != ST_IDLE)
    else $error("sample taken but sequencer stayed idle");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_idx == prc_pkg::IDX_W'(prc_pkg::DEPTH - 1)) |=> state == ST_DONE)
    else $error("scan did not end after one full rotation");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= prc_pkg::CNT_W'(prc_pkg::DEPTH))
    else $error("young count exceeds chain depth");

  a_rate_hold: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_DONE && refresh_q) |=> $stable(rate_value))
    else $error("rate changed without a recompute");

endmodule
